FILE: hdl/deqvr_pkg.sv
// Shared types and constants for the double-ended queue with value removal.
package deqvr_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int CMD_W     = 3;
	localparam int DATA_W    = 32;
	localparam int STAT_W    = 2;
	localparam int CNT_W     = 9;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_COUNT      = 3'd5;
	localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd6;
	localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd7;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic accept;
		logic exec;
		logic walk_step;
		logic walk_end;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic need_read;
		logic need_walk;
		logic walk_done;
	} dp_stat_t;

endpackage

FILE: hdl/deqvr_ctrl.sv
// Controller state machine sequencing each command through the datapath.
module deqvr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  deqvr_pkg::dp_stat_t stat,
	output deqvr_pkg::dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_READ   = 5'b00100,
		S_WALK   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt     = state_q;
		cmd           = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.need_read) begin
					state_nxt = S_READ;
				end else if (stat.need_walk) begin
					state_nxt = S_WALK;
				end else begin
					state_nxt = S_FINISH;
				end
			end
			S_READ: begin
				state_nxt = S_FINISH;
			end
			S_WALK: begin
				if (stat.walk_done) begin
					cmd.walk_end = 1'b1;
					state_nxt    = S_FINISH;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/deqvr_dp.sv
// Datapath: entry memory, head and count registers, walk counters, result registers.
module deqvr_dp #(
	parameter int DEPTH = deqvr_pkg::DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  deqvr_pkg::dp_cmd_t                   cmd,
	output deqvr_pkg::dp_stat_t                  stat,
	input  logic        [deqvr_pkg::CMD_W-1:0]   command,
	input  logic signed [deqvr_pkg::DATA_W-1:0]  value,
	output logic        [deqvr_pkg::STAT_W-1:0]  status,
	output logic signed [deqvr_pkg::DATA_W-1:0]  data,
	output logic        [deqvr_pkg::CNT_W-1:0]   match_count,
	output logic        [deqvr_pkg::CNT_W-1:0]   occupancy
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = deqvr_pkg::DATA_W;

	logic [DW-1:0] mem [DEPTH];

	logic [deqvr_pkg::CMD_W-1:0]  cmd_q;
	logic [DW-1:0]                val_q;
	logic [AW-1:0]                head_q;
	logic [CW-1:0]                count_q;
	logic [DW-1:0]                mem_rd_q;
	logic [AW-1:0]                rd_slot_q;
	logic [AW-1:0]                wr_slot_q;
	logic [CW-1:0]                rd_cnt_q;
	logic [CW-1:0]                kept_q;
	logic [CW-1:0]                matches_q;
	logic                         pend_s1;
	logic [deqvr_pkg::STAT_W-1:0] res_status_q;
	logic                         use_mem_q;
	logic [deqvr_pkg::STAT_W-1:0] status_q;
	logic [DW-1:0]                data_q;
	logic [deqvr_pkg::CNT_W-1:0]  match_count_q;
	logic [deqvr_pkg::CNT_W-1:0]  occupancy_q;

	logic          is_push;
	logic          is_pop;
	logic          is_peek;
	logic          is_walk;
	logic          is_front;
	logic          empty;
	logic          full;
	logic          hit;
	logic          more_reads;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] back_slot;
	logic [AW-1:0] tail_slot;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [DW-1:0] wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
		return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
	endfunction

	always_comb begin
		is_push = 1'b0;
		is_pop  = 1'b0;
		is_peek = 1'b0;
		is_walk = 1'b0;
		unique case (cmd_q) inside
			deqvr_pkg::CMD_PUSH_FRONT, deqvr_pkg::CMD_PUSH_BACK: is_push = 1'b1;
			deqvr_pkg::CMD_POP_FRONT, deqvr_pkg::CMD_POP_BACK:   is_pop  = 1'b1;
			deqvr_pkg::CMD_PEEK_FRONT, deqvr_pkg::CMD_PEEK_BACK: is_peek = 1'b1;
			default:                                             is_walk = 1'b1;
		endcase
	end

	assign is_front   = (cmd_q == deqvr_pkg::CMD_PUSH_FRONT) ||
	                    (cmd_q == deqvr_pkg::CMD_POP_FRONT) ||
	                    (cmd_q == deqvr_pkg::CMD_PEEK_FRONT);
	assign empty      = (count_q == '0);
	assign full       = (count_q == CW'(DEPTH));
	assign head_dec   = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign head_inc   = wrap_inc(head_q);
	assign back_slot  = wrap_add(head_q, AW'(count_q - 1'b1));
	assign tail_slot  = wrap_add(head_q, AW'(count_q));
	assign hit        = (mem_rd_q == val_q);
	assign more_reads = (rd_cnt_q != count_q);

	assign stat.need_read = (is_pop || is_peek) && !empty;
	assign stat.need_walk = is_walk && !empty;
	assign stat.walk_done = !more_reads && !pend_s1;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wr_slot_q;
		wr_data = mem_rd_q;
		rd_en   = 1'b0;
		rd_addr = rd_slot_q;
		if (cmd.exec) begin
			if (is_push && !full) begin
				wr_en   = 1'b1;
				wr_addr = is_front ? head_dec : tail_slot;
				wr_data = val_q;
			end
			if ((is_pop || is_peek) && !empty) begin
				rd_en   = 1'b1;
				rd_addr = is_front ? head_q : back_slot;
			end
		end
		if (cmd.walk_step) begin
			rd_en = more_reads;
			wr_en = pend_s1 && !hit && (cmd_q == deqvr_pkg::CMD_REMOVE);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (cmd.exec) begin
				pend_s1 <= 1'b0;
				if (is_push && !full) begin
					count_q <= count_q + 1'b1;
					if (is_front) begin
						head_q <= head_dec;
					end
				end
				if (is_pop && !empty) begin
					count_q <= count_q - 1'b1;
					if (is_front) begin
						head_q <= head_inc;
					end
				end
			end
			if (cmd.walk_step) begin
				pend_s1 <= more_reads;
			end
			if (cmd.walk_end && (cmd_q == deqvr_pkg::CMD_REMOVE)) begin
				count_q <= kept_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q <= command;
			val_q <= value;
		end
		if (cmd.exec) begin
			rd_slot_q <= head_q;
			wr_slot_q <= head_q;
			rd_cnt_q  <= '0;
			kept_q    <= '0;
			matches_q <= '0;
			use_mem_q <= (is_pop || is_peek) && !empty;
			if (is_push && full) begin
				res_status_q <= deqvr_pkg::STAT_FULL;
			end else if (!is_push && empty) begin
				res_status_q <= deqvr_pkg::STAT_EMPTY;
			end else begin
				res_status_q <= deqvr_pkg::STAT_OK;
			end
		end
		if (cmd.walk_step) begin
			if (more_reads) begin
				rd_slot_q <= wrap_inc(rd_slot_q);
				rd_cnt_q  <= rd_cnt_q + 1'b1;
			end
			if (pend_s1) begin
				if (hit) begin
					matches_q <= matches_q + 1'b1;
				end else begin
					kept_q    <= kept_q + 1'b1;
					wr_slot_q <= wrap_inc(wr_slot_q);
				end
			end
		end
		if (cmd.load_out) begin
			status_q      <= res_status_q;
			data_q        <= use_mem_q ? mem_rd_q : '0;
			match_count_q <= deqvr_pkg::CNT_W'(matches_q);
			occupancy_q   <= deqvr_pkg::CNT_W'(count_q);
		end
	end

	assign status      = status_q;
	assign data        = data_q;
	assign match_count = match_count_q;
	assign occupancy   = occupancy_q;

endmodule

FILE: hdl/double_ended_queue_with_value_removal_top.sv
// Top level of the bounded double-ended queue with value removal.
// Each command goes from the input transfer to execute, then to a memory read for pops
// and peeks or a walk for remove and count, and then to the result register.
// One item at a time; remove and count walk every entry through the single
// memory read port, so a new command is not taken until that walk and the result load are done.
// Reset empties the queue at once; no clearing pass is needed.
module double_ended_queue_with_value_removal_top #(
	parameter int DEPTH = deqvr_pkg::DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic        [deqvr_pkg::CMD_W-1:0]   command,
	input  logic signed [deqvr_pkg::DATA_W-1:0]  value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic        [deqvr_pkg::STAT_W-1:0]  status,
	output logic signed [deqvr_pkg::DATA_W-1:0]  data,
	output logic        [deqvr_pkg::CNT_W-1:0]   match_count,
	output logic        [deqvr_pkg::CNT_W-1:0]   occupancy
);

	deqvr_pkg::dp_cmd_t  dp_cmd;
	deqvr_pkg::dp_stat_t dp_stat;

	deqvr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	deqvr_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.command     (command),
		.value       (value),
		.status      (status),
		.data        (data),
		.match_count (match_count),
		.occupancy   (occupancy)
	);

endmodule

FILE: hdl/deqvr_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
module deqvr_checker #(
	parameter int DEPTH = deqvr_pkg::DEPTH_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic        [deqvr_pkg::STAT_W-1:0]  status,
	input logic signed [deqvr_pkg::DATA_W-1:0]  data,
	input logic        [deqvr_pkg::CNT_W-1:0]   match_count,
	input logic        [deqvr_pkg::CNT_W-1:0]   occupancy
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data) &&
			$stable(match_count) && $stable(occupancy))
		else $error("result changed while stalled");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == deqvr_pkg::STAT_FULL) |->
			(occupancy == deqvr_pkg::CNT_W'(DEPTH)) && (data == '0) && (match_count == '0))
		else $error("full status with wrong fields");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == deqvr_pkg::STAT_EMPTY) |->
			(occupancy == '0) && (data == '0) && (match_count == '0))
		else $error("empty status with wrong fields");

endmodule

bind double_ended_queue_with_value_removal_top deqvr_checker #(.DEPTH(DEPTH)) u_deqvr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.data        (data),
	.match_count (match_count),
	.occupancy   (occupancy)
);

FILE: dv/deqvr_result_monitor.sv
// Transfer monitor and result checker for the double-ended queue with value removal.
module deqvr_result_monitor #(
	parameter int DEPTH = deqvr_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic        [deqvr_pkg::CMD_W-1:0]  command,
	input  logic signed [deqvr_pkg::DATA_W-1:0] value,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic        [deqvr_pkg::STAT_W-1:0] status,
	input  logic signed [deqvr_pkg::DATA_W-1:0] data,
	input  logic        [deqvr_pkg::CNT_W-1:0]  match_count,
	input  logic        [deqvr_pkg::CNT_W-1:0]  occupancy,
	output int                                  fail_count,
	output int                                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        [deqvr_pkg::STAT_W-1:0] status;
		logic signed [deqvr_pkg::DATA_W-1:0] data;
		logic        [deqvr_pkg::CNT_W-1:0]  match_count;
		logic        [deqvr_pkg::CNT_W-1:0]  occupancy;
	} deq_result_t;

	logic signed [deqvr_pkg::DATA_W-1:0] deque_mirror[$];
	deq_result_t                         expected_results[$];

	function automatic deq_result_t apply_command(input logic [deqvr_pkg::CMD_W-1:0] cmd,
			input logic signed [deqvr_pkg::DATA_W-1:0] val);
		deq_result_t                         res;
		logic signed [deqvr_pkg::DATA_W-1:0] kept[$];
		int                                  hits;
		res  = '0;
		hits = 0;
		if (cmd == deqvr_pkg::CMD_PUSH_FRONT || cmd == deqvr_pkg::CMD_PUSH_BACK) begin
			if (deque_mirror.size() >= DEPTH) begin
				res.status = deqvr_pkg::STAT_FULL;
			end else if (cmd == deqvr_pkg::CMD_PUSH_FRONT) begin
				deque_mirror.push_front(val);
			end else begin
				deque_mirror.push_back(val);
			end
		end else if (deque_mirror.size() == 0) begin
			res.status = deqvr_pkg::STAT_EMPTY;
		end else begin
			case (cmd)
				deqvr_pkg::CMD_POP_FRONT:  res.data = deque_mirror.pop_front();
				deqvr_pkg::CMD_POP_BACK:   res.data = deque_mirror.pop_back();
				deqvr_pkg::CMD_PEEK_FRONT: res.data = deque_mirror[0];
				deqvr_pkg::CMD_PEEK_BACK:  res.data = deque_mirror[deque_mirror.size() - 1];
				deqvr_pkg::CMD_COUNT: begin
					foreach (deque_mirror[i])
						if (deque_mirror[i] == val)
							hits++;
				end
				default: begin
					foreach (deque_mirror[i]) begin
						if (deque_mirror[i] == val)
							hits++;
						else
							kept.push_back(deque_mirror[i]);
					end
					deque_mirror = kept;
				end
			endcase
		end
		res.match_count = deqvr_pkg::CNT_W'(hits);
		res.occupancy   = deqvr_pkg::CNT_W'(deque_mirror.size());
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deq_result_t want;
		deq_result_t got;
		if (!arst_n) begin
			deque_mirror.delete();
			expected_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				got = '{status, data, match_count, occupancy};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result status=%0d data=%0d count=%0d occ=%0d",
							$realtime, status, data, match_count, occupancy);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: exp st=%0d d=%0d mc=%0d occ=%0d got st=%0d d=%0d mc=%0d occ=%0d",
								$realtime,
								want.status, want.data, want.match_count, want.occupancy,
								status, data, match_count, occupancy);
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(apply_command(command, value));
		end
		outstanding = expected_results.size();
	end

endmodule

FILE: dv/testbench.sv
// Stimulus, clocking and verdict for the double-ended queue with value removal.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = deqvr_pkg::DEPTH_DEF;
	localparam int TOTAL_ITEMS = 1250;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 600;

	typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_MATCH} phase_t;

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                in_valid  = 1'b0;
	logic                                in_ready;
	logic        [deqvr_pkg::CMD_W-1:0]  command   = deqvr_pkg::CMD_PUSH_FRONT;
	logic signed [deqvr_pkg::DATA_W-1:0] value     = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic        [deqvr_pkg::STAT_W-1:0] status;
	logic signed [deqvr_pkg::DATA_W-1:0] data;
	logic        [deqvr_pkg::CNT_W-1:0]  match_count;
	logic        [deqvr_pkg::CNT_W-1:0]  occupancy;
	int                                  fail_count;
	int                                  outstanding;

	int                                  items_sent   = 0;
	int                                  results_seen = 0;
	bit                                  send_quiet   = 1'b0;
	bit                                  recv_quiet   = 1'b0;

	logic signed [deqvr_pkg::DATA_W-1:0] value_pool[6] = '{32'sd0, -32'sd1, 32'sd1, 32'sd7,
		32'sh8000_0000, 32'sh7fff_ffff};
	logic [deqvr_pkg::CMD_W-1:0] other_cmds[6] = '{deqvr_pkg::CMD_POP_FRONT,
		deqvr_pkg::CMD_POP_BACK, deqvr_pkg::CMD_PEEK_FRONT, deqvr_pkg::CMD_PEEK_BACK,
		deqvr_pkg::CMD_REMOVE, deqvr_pkg::CMD_COUNT};

	double_ended_queue_with_value_removal_top #(.DEPTH(DEPTH)) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.data        (data),
		.match_count (match_count),
		.occupancy   (occupancy)
	);

	deqvr_result_monitor #(.DEPTH(DEPTH)) u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.data        (data),
		.match_count (match_count),
		.occupancy   (occupancy),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_item(input logic [deqvr_pkg::CMD_W-1:0] cmd,
			input logic signed [deqvr_pkg::DATA_W-1:0] val);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		value    <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
		if (items_sent % 64 == 0)
			send_quiet = ($urandom_range(0, 3) == 0);
	endtask

	function automatic logic signed [deqvr_pkg::DATA_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 60)
			return value_pool[$urandom_range(0, 5)];
		return $urandom;
	endfunction

	task automatic send_phase(input phase_t kind, input int len);
		int                          push_pct;
		logic [deqvr_pkg::CMD_W-1:0] cmd;
		case (kind)
			PH_FILL:  push_pct = 92;
			PH_DRAIN: push_pct = 15;
			PH_MATCH: push_pct = 45;
			default:  push_pct = 50;
		endcase
		repeat (len) begin
			if (items_sent >= TOTAL_ITEMS)
				return;
			if ($urandom_range(0, 99) < push_pct)
				cmd = $urandom_range(0, 1) ? deqvr_pkg::CMD_PUSH_BACK :
					deqvr_pkg::CMD_PUSH_FRONT;
			else if (kind == PH_MATCH && $urandom_range(0, 99) < 70)
				cmd = $urandom_range(0, 1) ? deqvr_pkg::CMD_REMOVE : deqvr_pkg::CMD_COUNT;
			else
				cmd = other_cmds[$urandom_range(0, 5)];
			send_item(cmd, pick_value());
		end
	endtask

	initial begin
		#25_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver: random stalls, one long hold-off to back the block up
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = recv_quiet ? 0 : $urandom_range(0, 19);
			if (results_seen == HOLD_AT)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
			results_seen++;
			if (results_seen % 64 == 0)
				recv_quiet = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		phase_t kind;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(deqvr_pkg::CMD_POP_FRONT,  32'sd5);
		send_item(deqvr_pkg::CMD_POP_BACK,   32'sd5);
		send_item(deqvr_pkg::CMD_PEEK_FRONT, 32'sd0);
		send_item(deqvr_pkg::CMD_PEEK_BACK,  32'sd0);
		send_item(deqvr_pkg::CMD_REMOVE,     32'sd0);
		send_item(deqvr_pkg::CMD_COUNT,      32'sd0);
		send_item(deqvr_pkg::CMD_PUSH_BACK,  32'sh7fff_ffff);
		send_item(deqvr_pkg::CMD_PUSH_FRONT, 32'sh8000_0000);
		send_item(deqvr_pkg::CMD_PUSH_BACK,  32'sd0);
		send_item(deqvr_pkg::CMD_PUSH_BACK,  -32'sd1);
		send_item(deqvr_pkg::CMD_PUSH_FRONT, 32'sh8000_0000);
		send_item(deqvr_pkg::CMD_PEEK_FRONT, 32'sd0);
		send_item(deqvr_pkg::CMD_PEEK_BACK,  32'sd0);
		send_item(deqvr_pkg::CMD_COUNT,      32'sh8000_0000);
		send_item(deqvr_pkg::CMD_REMOVE,     32'sh8000_0000);
		send_item(deqvr_pkg::CMD_PEEK_FRONT, 32'sd0);
		send_item(deqvr_pkg::CMD_COUNT,      32'sd5);
		send_item(deqvr_pkg::CMD_REMOVE,     32'sd5);
		send_item(deqvr_pkg::CMD_POP_BACK,   32'sd0);
		send_item(deqvr_pkg::CMD_POP_FRONT,  32'sd0);
		send_item(deqvr_pkg::CMD_POP_FRONT,  32'sd0);
		send_item(deqvr_pkg::CMD_POP_FRONT,  32'sd0);

		send_phase(PH_FILL, 320);
		while (items_sent < TOTAL_ITEMS) begin
			kind = phase_t'($urandom_range(0, 3));
			send_phase(kind, $urandom_range(20, 120));
		end
		in_valid <= 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (DEPTH + 10) @(negedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
